@@ design/hrf_pkg.sv @@
// Shared types, codes and constants for the HTTP response framer.
// No dependencies; imported by every module of the framer.
package hrf_pkg;

   localparam int KEY_LEN = 14;
   localparam logic [15:0] LIMIT_RESET = 16'd1024;
   localparam logic [15:0] STATUS_OFFSET = 16'd9;
   localparam logic [9:0] STATUS_MAX = 10'd999;
   localparam int QUEUE_DEPTH = 4;

   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_RESTART = 1'b1;

   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_BODY = 2'd1;
   localparam logic [1:0] PH_CLOSED = 2'd2;

   localparam logic [1:0] LS_SEARCH = 2'd0;
   localparam logic [1:0] LS_SKIP = 2'd1;
   localparam logic [1:0] LS_DIGITS = 2'd2;
   localparam logic [1:0] LS_DONE = 2'd3;

   localparam logic [1:0] SS_SKIP = 2'd0;
   localparam logic [1:0] SS_DIGITS = 2'd1;
   localparam logic [1:0] SS_DONE = 2'd2;

   localparam logic [2:0] EV_HDR_BYTE = 3'd0;
   localparam logic [2:0] EV_HDR_DONE = 3'd1;
   localparam logic [2:0] EV_BODY_BYTE = 3'd2;
   localparam logic [2:0] EV_END = 3'd3;
   localparam logic [2:0] EV_OVERFLOW = 3'd4;
   localparam logic [2:0] EV_NO_LENGTH = 3'd5;
   localparam logic [2:0] EV_DROPPED = 3'd6;
   localparam logic [2:0] EV_RESTARTED = 3'd7;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_VT = 8'h0B;
   localparam logic [7:0] CH_FF = 8'h0C;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_BIT = 8'h20;
   localparam logic [23:0] TAIL_CRLFCR = 24'h0D0A0D;

   typedef struct packed {
      logic [1:0]  phase;
      logic [15:0] header_count;
      logic [23:0] tail_window;
      logic [3:0]  match_pos;
      logic [1:0]  length_stage;
      logic [31:0] length_value;
      logic [9:0]  status_value;
      logic [31:0] body_remaining;
      logic [1:0]  status_stage;
   } hrf_state_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [7:0]  data_byte;
      logic [9:0]  status_code;
      logic [31:0] content_length;
      logic        last;
   } hrf_result_type;

   // "content-length", lower case
   function automatic logic [7:0] key_char(input logic [3:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:  ch = 8'h63;
         4'd1:  ch = 8'h6F;
         4'd2:  ch = 8'h6E;
         4'd3:  ch = 8'h74;
         4'd4:  ch = 8'h65;
         4'd5:  ch = 8'h6E;
         4'd6:  ch = 8'h74;
         4'd7:  ch = 8'h2D;
         4'd8:  ch = 8'h6C;
         4'd9:  ch = 8'h65;
         4'd10: ch = 8'h6E;
         4'd11: ch = 8'h67;
         4'd12: ch = 8'h74;
         4'd13: ch = 8'h68;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

@@ design/http_response_framer_unit.sv @@
// HTTP response framer top level: request register, parser and result queue.
// A request's first response passes the request register, then the result queue.
// Throughput: 1 request per cycle while the result queue has room for two responses;
// two-response requests (header done with end or no length, last body byte) share the
// one-per-cycle response port, so req_ready drops once the queue holds three responses.
// Depends on hrf_pkg, hrf_parse, hrf_result_queue. Reset clears state, queue; limit=1024.
module http_response_framer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_res,
   output logic [7:0]  rsp_data_byte,
   output logic [9:0]  rsp_status_code,
   output logic [31:0] rsp_content_length,
   output logic        rsp_last,
   input  logic        csr_write_en,
   input  logic [15:0] csr_write_data
);
   import hrf_pkg::*;

   logic           in_valid_ff, in_valid_in;
   logic           in_action_ff;
   logic [7:0]     in_byte_ff;
   logic [15:0]    header_limit_ff, header_limit_in;
   hrf_state_type  state_ff, state_in;
   hrf_state_type  state_next;
   hrf_result_type res0, res1, rsp_res;
   logic           two;
   logic           room;
   logic           advance;
   logic           req_take;

   assign advance = in_valid_ff && room;
   assign req_ready = !in_valid_ff || advance;
   assign req_take = req_valid && req_ready;
   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign header_limit_in = csr_write_en ? csr_write_data : header_limit_ff;
   assign state_in = advance ? state_next : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         header_limit_ff <= LIMIT_RESET;
         state_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         header_limit_ff <= header_limit_in;
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff <= req_action;
         in_byte_ff <= req_rx_byte;
      end
   end

   hrf_parse u_parse (
      .cur          (state_ff),
      .action       (in_action_ff),
      .rx_byte      (in_byte_ff),
      .header_limit (header_limit_ff),
      .nxt          (state_next),
      .res0         (res0),
      .res1         (res1),
      .two          (two)
   );

   hrf_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (advance),
      .push_two  (two),
      .push_res0 (res0),
      .push_res1 (res1),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_res   (rsp_res)
   );

   assign rsp_event_res = rsp_res.event_res;
   assign rsp_data_byte = rsp_res.data_byte;
   assign rsp_status_code = rsp_res.status_code;
   assign rsp_content_length = rsp_res.content_length;
   assign rsp_last = rsp_res.last;

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && in_action_ff == ACT_RESTART) |=>
      (state_ff.phase == PH_HEADER && state_ff.header_count == 16'd0))
      else $error("restart did not clear parser state");
   a_body_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_BODY) |-> (state_ff.body_remaining != 32'd0))
      else $error("body phase with nothing remaining");
   a_two_ends_request: assert property (@(posedge clock) disable iff (reset)
      (advance && two) |-> (!res0.last && res1.last))
      else $error("response pair has wrong last marks");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.status_value <= STATUS_MAX)
      else $error("status code above saturation");

endmodule

@@ design/hrf_parse.sv @@
// Per-request next-state and result logic of the framer (combinational).
// Depends on hrf_pkg.
module hrf_parse (
   input  hrf_pkg::hrf_state_type  cur,
   input  logic                    action,
   input  logic [7:0]              rx_byte,
   input  logic [15:0]             header_limit,
   output hrf_pkg::hrf_state_type  nxt,
   output hrf_pkg::hrf_result_type res0,
   output hrf_pkg::hrf_result_type res1,
   output logic                    two
);
   import hrf_pkg::*;

   hrf_state_type scan;
   logic [7:0]    lc;
   logic [3:0]    digit_val;
   logic          digit;
   logic          ws;
   logic [13:0]   status_mac;
   logic [35:0]   length_mac;
   logic [3:0]    mp;
   logic          done;
   logic [31:0]   remaining;

   assign lc = (rx_byte >= CH_UPPER_A && rx_byte <= CH_UPPER_Z) ? (rx_byte | CASE_BIT) : rx_byte;
   assign digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
   assign digit_val = 4'(rx_byte - CH_ZERO);
   assign ws = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB) || (rx_byte == CH_LF) ||
               (rx_byte == CH_CR) || (rx_byte == CH_VT) || (rx_byte == CH_FF);
   assign status_mac = ({4'd0, cur.status_value} << 3) + ({4'd0, cur.status_value} << 1)
                       + {10'd0, digit_val};
   assign length_mac = ({4'd0, cur.length_value} << 3) + ({4'd0, cur.length_value} << 1)
                       + {32'd0, digit_val};

   // header byte scan: status code and content-length field
   always_comb begin
      scan = cur;
      mp = 4'd0;
      if (cur.header_count >= STATUS_OFFSET && cur.status_stage < SS_DONE) begin
         if (digit) begin
            scan.status_stage = SS_DIGITS;
            scan.status_value = (status_mac > 14'(STATUS_MAX)) ? STATUS_MAX : status_mac[9:0];
         end else if (!(cur.status_stage == SS_SKIP && ws)) begin
            scan.status_stage = SS_DONE;
         end
      end
      case (cur.length_stage)
         LS_SEARCH: begin
            if (cur.match_pos < 4'(KEY_LEN) && lc == key_char(cur.match_pos)) begin
               mp = cur.match_pos + 4'd1;
            end else begin
               mp = (lc == key_char(4'd0)) ? 4'd1 : 4'd0;
            end
            scan.match_pos = mp;
            if (mp >= 4'(KEY_LEN)) begin
               scan.length_stage = LS_SKIP;
            end
         end
         LS_SKIP, LS_DIGITS: begin
            if (cur.length_stage == LS_SKIP &&
                (rx_byte == CH_SPACE || rx_byte == CH_TAB || rx_byte == CH_COLON)) begin
               scan.length_stage = cur.length_stage;
            end else if (digit) begin
               scan.length_value = (length_mac[35:32] != 4'd0) ? 32'hFFFF_FFFF
                                                                : length_mac[31:0];
               scan.length_stage = LS_DIGITS;
            end else begin
               scan.length_stage = LS_DONE;
            end
         end
         default: begin
            scan.length_stage = cur.length_stage;
         end
      endcase
   end

   assign done = (cur.header_count >= 16'd3) && (cur.tail_window == TAIL_CRLFCR) &&
                 (rx_byte == CH_LF);
   assign remaining = (cur.body_remaining != 32'd0) ? cur.body_remaining - 32'd1
                                                    : cur.body_remaining;

   always_comb begin
      nxt = cur;
      res0 = '0;
      res1 = '0;
      two = 1'b0;
      if (action == ACT_RESTART) begin
         nxt = '0;
         res0.event_res = EV_RESTARTED;
         res0.last = 1'b1;
      end else begin
         case (cur.phase)
            PH_HEADER: begin
               if (cur.header_count >= header_limit) begin
                  nxt.phase = PH_CLOSED;
                  res0.event_res = EV_OVERFLOW;
                  res0.last = 1'b1;
               end else begin
                  nxt = scan;
                  nxt.header_count = cur.header_count + 16'd1;
                  nxt.tail_window = {cur.tail_window[15:0], rx_byte};
                  if (!done) begin
                     res0.event_res = EV_HDR_BYTE;
                     res0.last = 1'b1;
                  end else begin
                     res0.event_res = EV_HDR_DONE;
                     res0.status_code = scan.status_value;
                     nxt = '0;
                     if (scan.length_stage == LS_SEARCH) begin
                        nxt.phase = PH_CLOSED;
                        res1.event_res = EV_NO_LENGTH;
                        res1.last = 1'b1;
                        two = 1'b1;
                     end else if (scan.length_value == 32'd0) begin
                        res1.event_res = EV_END;
                        res1.last = 1'b1;
                        two = 1'b1;
                     end else begin
                        res0.content_length = scan.length_value;
                        res0.last = 1'b1;
                        nxt.phase = PH_BODY;
                        nxt.body_remaining = scan.length_value;
                     end
                  end
               end
            end
            PH_BODY: begin
               res0.event_res = EV_BODY_BYTE;
               res0.data_byte = rx_byte;
               if (remaining == 32'd0) begin
                  nxt = '0;
                  res1.event_res = EV_END;
                  res1.last = 1'b1;
                  two = 1'b1;
               end else begin
                  nxt.body_remaining = remaining;
                  res0.last = 1'b1;
               end
            end
            default: begin
               res0.event_res = EV_DROPPED;
               res0.last = 1'b1;
            end
         endcase
      end
   end

endmodule

@@ design/hrf_result_queue.sv @@
// Result queue: takes one or two responses per cycle while it has room, hands out one per cycle when taken.
// Depends on hrf_pkg.
module hrf_result_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic                    push_two,
   input  hrf_pkg::hrf_result_type push_res0,
   input  hrf_pkg::hrf_result_type push_res1,
   output logic                    room,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output hrf_pkg::hrf_result_type rsp_res
);
   import hrf_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   hrf_result_type   slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_ptr_next;
   logic             pop;
   logic [CNT_W-1:0] n_push;

   assign wr_ptr_next = wr_ptr_ff + PTR_W'(1);
   assign pop = rsp_valid && rsp_ready;
   assign n_push = push ? (push_two ? CNT_W'(2) : CNT_W'(1)) : CNT_W'(0);
   assign room = count_ff <= CNT_W'(QUEUE_DEPTH - 2);
   assign rsp_valid = count_ff != CNT_W'(0);
   assign rsp_res = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff + n_push[PTR_W-1:0];
   assign rd_ptr_in = rd_ptr_ff + (pop ? PTR_W'(1) : PTR_W'(0));
   assign count_in = count_ff + n_push - (pop ? CNT_W'(1) : CNT_W'(0));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_res0;
         if (push_two) begin
            slot_ff[wr_ptr_next] <= push_res1;
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("result queue count out of range");
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push |-> room)
      else $error("push into result queue without room");
   a_pointer_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff != CNT_W'(0) && count_ff != CNT_W'(QUEUE_DEPTH)) |->
      (wr_ptr_ff != rd_ptr_ff))
      else $error("result queue pointers disagree with count");

endmodule

@@ sim/tb.sv @@
// Testbench for http_response_framer_unit: directed and random HTTP responses fed byte by byte,
// each result checked against a framing model kept in this file.
// Depends on hrf_pkg and http_response_framer_unit.
`timescale 1ns / 1ps

module tb;
   import hrf_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 6;
   localparam string CRLF = "\015\012";
   localparam logic [8*KEY_LEN-1:0] LENGTH_KEY = "content-length";

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_action = ACT_BYTE;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_event_res;
   logic [7:0]  rsp_data_byte;
   logic [9:0]  rsp_status_code;
   logic [31:0] rsp_content_length;
   logic        rsp_last;
   logic        csr_write_en = 1'b0;
   logic [15:0] csr_write_data = 16'h0000;

   hrf_state_type  framer_model = '0;
   logic [15:0]    model_limit = LIMIT_RESET;
   hrf_result_type expected_events[$];
   int             error_count = 0;
   int             cycle_count = 0;
   int             framed_count = 0;
   int             burst_left = 0;
   bit             gaps_on = 1'b1;
   int             stall_mode = 0;
   int             stall_tick = 0;

   http_response_framer_unit DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_res      (rsp_event_res),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_status_code    (rsp_status_code),
      .rsp_content_length (rsp_content_length),
      .rsp_last           (rsp_last),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------- framing model ----------------

   function automatic void expect_event(input logic [2:0] ev, input logic [7:0] db,
                                        input logic [9:0] st, input logic [31:0] len,
                                        input logic last);
      hrf_result_type r;
      r.event_res = ev;
      r.data_byte = db;
      r.status_code = st;
      r.content_length = len;
      r.last = last;
      expected_events.push_back(r);
   endfunction

   function automatic logic [7:0] key_at(input int i);
      return LENGTH_KEY[8*(KEY_LEN-1-i) +: 8];
   endfunction

   function automatic bit is_blank(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
             c == CH_VT || c == CH_FF;
   endfunction

   function automatic void scan_header(input logic [7:0] c);
      logic [7:0]  lc;
      bit          digit;
      int unsigned status_next;
      logic [63:0] length_next;
      lc = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_BIT : c;
      digit = c >= CH_ZERO && c <= CH_NINE;
      if (framer_model.header_count >= STATUS_OFFSET && framer_model.status_stage < SS_DONE) begin
         if (digit) begin
            framer_model.status_stage = SS_DIGITS;
            status_next = framer_model.status_value * 10 + (c - CH_ZERO);
            framer_model.status_value = (status_next > STATUS_MAX) ? STATUS_MAX
                                                                   : status_next[9:0];
         end else if (!(framer_model.status_stage == SS_SKIP && is_blank(c))) begin
            framer_model.status_stage = SS_DONE;
         end
      end
      if (framer_model.length_stage == LS_SEARCH) begin
         if (framer_model.match_pos < KEY_LEN && lc == key_at(framer_model.match_pos))
            framer_model.match_pos = framer_model.match_pos + 4'd1;
         else
            framer_model.match_pos = (lc == key_at(0)) ? 4'd1 : 4'd0;
         if (framer_model.match_pos >= KEY_LEN) framer_model.length_stage = LS_SKIP;
      end else if (framer_model.length_stage == LS_SKIP ||
                   framer_model.length_stage == LS_DIGITS) begin
         if (!(framer_model.length_stage == LS_SKIP &&
               (c == CH_SPACE || c == CH_TAB || c == CH_COLON))) begin
            if (digit) begin
               length_next = framer_model.length_value * 64'd10 + (c - CH_ZERO);
               framer_model.length_value = (length_next > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                                        : length_next[31:0];
               framer_model.length_stage = LS_DIGITS;
            end else begin
               framer_model.length_stage = LS_DONE;
            end
         end
      end
   endfunction

   function automatic void frame_request(input logic act, input logic [7:0] c);
      bit          header_done;
      logic [9:0]  status_seen;
      logic [31:0] length_seen;
      framed_count++;
      if (act == ACT_RESTART) begin
         framer_model = '0;
         expect_event(EV_RESTARTED, 8'h00, 10'd0, 32'd0, 1'b1);
      end else if (framer_model.phase == PH_HEADER) begin
         if (framer_model.header_count >= model_limit) begin
            framer_model.phase = PH_CLOSED;
            expect_event(EV_OVERFLOW, 8'h00, 10'd0, 32'd0, 1'b1);
         end else begin
            scan_header(c);
            header_done = framer_model.header_count >= 3 &&
                          framer_model.tail_window == TAIL_CRLFCR && c == CH_LF;
            framer_model.header_count = framer_model.header_count + 16'd1;
            framer_model.tail_window = {framer_model.tail_window[15:0], c};
            status_seen = framer_model.status_value;
            length_seen = framer_model.length_value;
            if (!header_done) begin
               expect_event(EV_HDR_BYTE, 8'h00, 10'd0, 32'd0, 1'b1);
            end else if (framer_model.length_stage == LS_SEARCH) begin
               expect_event(EV_HDR_DONE, 8'h00, status_seen, 32'd0, 1'b0);
               framer_model = '0;
               framer_model.phase = PH_CLOSED;
               expect_event(EV_NO_LENGTH, 8'h00, 10'd0, 32'd0, 1'b1);
            end else if (length_seen == 32'd0) begin
               expect_event(EV_HDR_DONE, 8'h00, status_seen, 32'd0, 1'b0);
               framer_model = '0;
               expect_event(EV_END, 8'h00, 10'd0, 32'd0, 1'b1);
            end else begin
               expect_event(EV_HDR_DONE, 8'h00, status_seen, length_seen, 1'b1);
               framer_model = '0;
               framer_model.phase = PH_BODY;
               framer_model.body_remaining = length_seen;
            end
         end
      end else if (framer_model.phase == PH_BODY) begin
         if (framer_model.body_remaining != 32'd0)
            framer_model.body_remaining = framer_model.body_remaining - 32'd1;
         if (framer_model.body_remaining == 32'd0) begin
            expect_event(EV_BODY_BYTE, c, 10'd0, 32'd0, 1'b0);
            framer_model = '0;
            expect_event(EV_END, 8'h00, 10'd0, 32'd0, 1'b1);
         end else begin
            expect_event(EV_BODY_BYTE, c, 10'd0, 32'd0, 1'b1);
         end
      end else begin
         expect_event(EV_DROPPED, 8'h00, 10'd0, 32'd0, 1'b1);
      end
   endfunction

   // ---------------- response side ----------------

   always @(negedge clock) begin
      stall_tick <= stall_tick + 1;
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= ((stall_tick % 8) >= 5);
         default: rsp_ready <= 1'($urandom_range(0, 1));
      endcase
      if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
   end

   always @(posedge clock) begin : check_results
      hrf_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_events.size() == 0) begin
            $error("unexpected result, event_res %0d", rsp_event_res);
            error_count++;
         end else begin
            want = expected_events.pop_front();
            if (rsp_event_res !== want.event_res) begin
               $error("event_res expected %0d got %0d", want.event_res, rsp_event_res);
               error_count++;
            end
            if (rsp_data_byte !== want.data_byte) begin
               $error("data_byte expected %0h got %0h", want.data_byte, rsp_data_byte);
               error_count++;
            end
            if (rsp_status_code !== want.status_code) begin
               $error("status_code expected %0d got %0d", want.status_code, rsp_status_code);
               error_count++;
            end
            if (rsp_content_length !== want.content_length) begin
               $error("content_length expected %0d got %0d",
                      want.content_length, rsp_content_length);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last expected %0d got %0d", want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------- request side ----------------

   task automatic send_request(input logic act, input logic [7:0] c);
      int gap;
      if (burst_left == 0) begin
         if (gaps_on) begin
            gap = $urandom_range(0, 6);
            repeat (gap) begin
               @(negedge clock);
               req_valid <= 1'b0;
               @(posedge clock);
            end
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_action <= act;
      req_rx_byte <= c;
      do @(posedge clock); while (!req_ready);
      frame_request(act, c);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_request(ACT_BYTE, s[i]);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_limit(input logic [15:0] value);
      drain_results();
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      model_limit = value;
   endtask

   // ---------------- random response pieces ----------------

   task automatic send_status();
      case ($urandom_range(0, 4))
         0: send_text({"\011 ", $sformatf("%0d", $urandom_range(100, 599))});
         1: send_text("12345");
         2: send_text("");
         default: send_text($sformatf("%03d", $urandom_range(0, 999)));
      endcase
   endtask

   task automatic send_filler_line();
      case ($urandom_range(0, 3))
         0: send_text("Content-Type: text/html");
         1: send_text("content-lengt: 9");
         2: send_text("Server: cco");
         default: repeat ($urandom_range(1, 12))
            send_request(ACT_BYTE, 8'($urandom_range(32, 126)));
      endcase
      send_text(CRLF);
   endtask

   task automatic send_length_line();
      logic [7:0] ch;
      string      digits;
      for (int i = 0; i < KEY_LEN; i++) begin
         ch = key_at(i);
         if (ch >= "a" && ch <= "z" && $urandom_range(0, 1)) ch = ch - CASE_BIT;
         send_request(ACT_BYTE, ch);
      end
      repeat ($urandom_range(0, 3)) begin
         case ($urandom_range(0, 2))
            0: send_request(ACT_BYTE, CH_COLON);
            1: send_request(ACT_BYTE, CH_SPACE);
            default: send_request(ACT_BYTE, CH_TAB);
         endcase
      end
      case ($urandom_range(0, 7))
         0: digits = "0";
         1: digits = "-12";
         2: digits = $urandom_range(0, 1) ? "4294967295" : "987654321012";
         3: digits = "";
         4: digits = "007x";
         default: digits = $sformatf("%0d", $urandom_range(1, 12));
      endcase
      send_text({digits, CRLF});
   endtask

   task automatic send_body();
      int unsigned n;
      n = framer_model.body_remaining;
      if (n > 40 || $urandom_range(0, 5) == 0) n = $urandom_range(0, (n > 40) ? 6 : n);
      repeat (n) send_request(ACT_BYTE, 8'($urandom_range(0, 255)));
      if (framer_model.phase == PH_BODY)
         send_request(ACT_RESTART, 8'($urandom_range(0, 255)));
   endtask

   task automatic random_response();
      if (framer_model.phase != PH_HEADER || $urandom_range(0, 3) == 0)
         send_request(ACT_RESTART, 8'($urandom_range(0, 255)));
      case ($urandom_range(0, 9))
         0: begin
            repeat ($urandom_range(1, 30))
               send_request(($urandom_range(0, 15) == 0) ? ACT_RESTART : ACT_BYTE,
                            8'($urandom_range(0, 255)));
         end
         1: begin
            send_text("HTTP/1.1 ");
            send_status();
            send_text(" OK");
            send_request(ACT_RESTART, 8'($urandom_range(0, 255)));
         end
         2: begin
            send_text("HTTP/1.1 ");
            send_status();
            send_text({" OK", CRLF});
            if ($urandom_range(0, 1)) send_filler_line();
            send_text(CRLF);
            repeat ($urandom_range(0, 3)) send_request(ACT_BYTE, 8'($urandom_range(0, 255)));
         end
         default: begin
            send_text("HTTP/1.1 ");
            send_status();
            send_text({" OK", CRLF});
            if ($urandom_range(0, 1)) send_filler_line();
            send_length_line();
            if ($urandom_range(0, 2) == 0) send_filler_line();
            if ($urandom_range(0, 4) == 0) send_length_line();
            send_text(CRLF);
            if (framer_model.phase == PH_BODY) send_body();
         end
      endcase
   endtask

   // ---------------- tests ----------------

   task automatic test_restart();
      send_request(ACT_RESTART, 8'hFF);
      drain_results();
   endtask

   task automatic test_missing_length();
      send_text({CRLF, CRLF});
      send_request(ACT_BYTE, 8'h00);
      send_request(ACT_RESTART, 8'h00);
      drain_results();
   endtask

   task automatic test_header_limit();
      write_limit(16'd0);
      send_request(ACT_BYTE, 8'h41);
      send_request(ACT_BYTE, 8'h80);
      send_request(ACT_RESTART, 8'h00);
      write_limit(16'd4);
      send_text("abcde");
      send_request(ACT_RESTART, 8'h00);
      write_limit(LIMIT_RESET);
   endtask

   task automatic test_zero_length();
      send_text({"HTTP/1.1 204 ", CRLF, "content-length:-7", CRLF, CRLF});
      drain_results();
   endtask

   task automatic test_body_passthrough();
      // saturated status and length, body cut short by a restart
      send_text({"HTTP/1.1 99999", CRLF, "CONTENT-LENGTH: \0114294967299", CRLF, CRLF});
      send_request(ACT_BYTE, 8'h00);
      send_request(ACT_BYTE, 8'hFF);
      send_request(ACT_RESTART, 8'h55);
      send_text({"HTTP/1.1 \011 200 OK", CRLF, "Content-Length: 2", CRLF, CRLF});
      send_request(ACT_BYTE, 8'h00);
      send_request(ACT_BYTE, 8'hFF);
      drain_results();
   endtask

   task automatic run_random(input int n);
      int start;
      start = framed_count;
      while (framed_count - start < n) random_response();
   endtask

   task automatic test_random_traffic();
      write_limit(16'hFFFF);
      run_random(220);
      write_limit(16'd40);
      run_random(130);
      gaps_on = 1'b0;
      write_limit(LIMIT_RESET);
      run_random(180);
      gaps_on = 1'b1;
      write_limit(16'($urandom_range(60, 300)));
      run_random(170);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_restart();
      test_missing_length();
      test_header_limit();
      test_zero_length();
      test_body_passthrough();
      test_random_traffic();
      drain_results();
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
design/hrf_pkg.sv
design/hrf_parse.sv
design/hrf_result_queue.sv
design/http_response_framer_unit.sv
sim/tb.sv
